@@ rtl/bucketed_hash_table_depth_age_replace_macros.svh @@
// Assertion macros for the bucketed hash table.
// Used by the top level; depends on nothing else.
`ifndef BUCKETED_HASH_TABLE_DEPTH_AGE_REPLACE_MACROS_SVH
`define BUCKETED_HASH_TABLE_DEPTH_AGE_REPLACE_MACROS_SVH

// Same-cycle implication under the active-low reset.
`define BHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the active-low reset.
`define BHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bht_pkg.sv @@
// Shared types and codes of the bucketed hash table.
// No dependencies.
`default_nettype none

package bht_pkg;

    localparam logic [1:0] FUNC_PROBE = 2'd0;
    localparam logic [1:0] FUNC_STORE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_EXACT = 2'd3;

    typedef struct packed {
        logic [31:0]        tag;
        logic [15:0]        move;
        logic signed [15:0] score;
        logic signed [15:0] eval;
        logic signed [7:0]  depth;
        logic [5:0]         gen;
        logic [1:0]         bound;
    } entry_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CLEAR,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic ready;
        logic sweep;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_clear;
        logic sweep_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/bht_if.sv @@
// Query and result channel interfaces of the bucketed hash table.
// No dependencies.
`default_nettype none

interface bht_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [63:0]        position_key;
    logic [15:0]        best_move;
    logic signed [15:0] search_score;
    logic signed [15:0] static_eval;
    logic signed [7:0]  search_depth;
    logic [1:0]         bound_kind;

    modport source (output valid, func, position_key, best_move, search_score,
                    static_eval, search_depth, bound_kind, input ready);
    modport sink (input valid, func, position_key, best_move, search_score,
                  static_eval, search_depth, bound_kind, output ready);
endinterface

interface bht_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [15:0]        hit_move;
    logic signed [15:0] hit_score;
    logic signed [15:0] hit_eval;
    logic signed [7:0]  hit_depth;
    logic [1:0]         hit_bound;
    logic               written;

    modport source (output valid, hit, hit_move, hit_score, hit_eval, hit_depth,
                    hit_bound, written, input ready);
    modport sink (input valid, hit, hit_move, hit_score, hit_eval, hit_depth,
                  hit_bound, written, output ready);
endinterface

`default_nettype wire

@@ rtl/bht_ctrl.sv @@
// Controller state machine of the bucketed hash table.
// Depends on bht_pkg.
`default_nettype none

module bht_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  bht_pkg::status_t status,
    output bht_pkg::cmd_t    cmd
);
    import bht_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_SWEEP;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: if (status.sweep_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (status.in_valid)
                    state_next = status.in_clear ? ST_CLEAR : ST_EXEC;
            end
            ST_CLEAR: if (status.sweep_last) state_next = ST_EXEC;
            ST_EXEC:  if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_SWEEP;
        endcase
    end

    always_comb
    begin
        cmd.ready = (state_reg == ST_IDLE);
        cmd.sweep = (state_reg == ST_SWEEP) || (state_reg == ST_CLEAR);
        cmd.exec  = (state_reg == ST_EXEC) && status.out_free;
    end

endmodule

`default_nettype wire

@@ rtl/bht_datapath.sv @@
// Datapath of the bucketed hash table: bucket memory, way compare, replace
// choice and result register. Depends on bht_pkg and bht_if.
`default_nettype none

module bht_datapath #(
    parameter int BUCKET_BITS = 14,
    parameter int WAYS        = 4
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             cfg_we,
    input  wire [5:0]       cfg_wdata,
    bht_in_if.sink          query,
    bht_out_if.source       result,
    input  bht_pkg::cmd_t   cmd,
    output bht_pkg::status_t status
);
    import bht_pkg::*;

    localparam int BUCKETS = 1 << BUCKET_BITS;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    entry_t [WAYS-1:0] mem [BUCKETS];

    entry_t [WAYS-1:0]      rd_row_reg;
    entry_t [WAYS-1:0]      wr_row;
    logic [BUCKET_BITS-1:0] sweep_cnt_reg;
    logic [BUCKET_BITS-1:0] bucket_reg;
    logic [1:0]             func_reg;
    logic [31:0]            tag_reg;
    logic [15:0]            move_reg;
    logic signed [15:0]     score_reg;
    logic signed [15:0]     eval_reg;
    logic signed [7:0]      depth_reg;
    logic [1:0]             bound_reg;
    logic [5:0]             gen_reg;
    logic [5:0]             gen_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic                   load;
    logic                   mem_we;
    logic [BUCKET_BITS-1:0] mem_waddr;
    entry_t [WAYS-1:0]      mem_wdata;

    logic                   probe_hit;
    entry_t                 probe_entry;
    logic [WAY_W-1:0]       pick_idx;
    entry_t                 pick_entry;
    entry_t                 new_entry;
    logic                   tag_same;
    logic                   skip;
    logic signed [9:0]      way_value [WAYS];

    assign load = query.valid && cmd.ready;

    assign status.in_valid   = query.valid;
    assign status.in_clear   = (query.func == FUNC_CLEAR);
    assign status.sweep_last = (sweep_cnt_reg == BUCKET_BITS'(BUCKETS - 1));
    assign status.out_free   = !out_valid_reg || result.ready;
    assign query.ready       = cmd.ready;

    // Bucket memory: one row per bucket, read on accept, written back on a store execute, zeroed by a sweep.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (load)
            rd_row_reg <= mem[query.position_key[63 -: BUCKET_BITS]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep)
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        gen_next = gen_reg;
        if (cfg_we)
            gen_next = cfg_wdata;
        else if (load && status.in_clear)
            gen_next = '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg   <= query.func;
            bucket_reg <= query.position_key[63 -: BUCKET_BITS];
            tag_reg    <= query.position_key[31:0];
            move_reg   <= query.best_move;
            score_reg  <= query.search_score;
            eval_reg   <= query.static_eval;
            depth_reg  <= query.search_depth;
            bound_reg  <= query.bound_kind;
        end
    end

    // Probe: first way with matching tag and a bound.
    always_comb
    begin
        probe_hit   = 1'b0;
        probe_entry = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!probe_hit && rd_row_reg[i].tag == tag_reg
                && rd_row_reg[i].bound != BOUND_NONE)
            begin
                probe_hit   = 1'b1;
                probe_entry = rd_row_reg[i];
            end
        end
    end

    // Replacement value: depth minus twice the age.
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            way_value[i] = 10'({{2{rd_row_reg[i].depth[7]}}, rd_row_reg[i].depth})
                - 10'({3'b000, 6'(gen_reg - rd_row_reg[i].gen), 1'b0});
        end
    end

    always_comb
    begin
        logic done;
        done     = 1'b0;
        pick_idx = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!done)
            begin
                if (rd_row_reg[i].tag == tag_reg || rd_row_reg[i].bound == BOUND_NONE)
                begin
                    pick_idx = WAY_W'(i);
                    done     = 1'b1;
                end
                else if (way_value[i] < way_value[pick_idx])
                    pick_idx = WAY_W'(i);
            end
        end
    end

    assign pick_entry = rd_row_reg[pick_idx];
    assign tag_same   = (pick_entry.tag == tag_reg);
    assign skip       = tag_same && (bound_reg != BOUND_EXACT)
        && ($signed({depth_reg[7], depth_reg})
            < $signed({pick_entry.depth[7], pick_entry.depth}) - 9'sd3);

    always_comb
    begin
        new_entry.tag   = tag_reg;
        new_entry.move  = (move_reg == 16'd0 && tag_same) ? pick_entry.move : move_reg;
        new_entry.score = score_reg;
        new_entry.eval  = eval_reg;
        new_entry.depth = depth_reg;
        new_entry.gen   = gen_reg;
        new_entry.bound = bound_reg;
        wr_row           = rd_row_reg;
        wr_row[pick_idx] = new_entry;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = bucket_reg;
        mem_wdata = wr_row;
        if (cmd.sweep)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            mem_wdata = '0;
        end
        else if (cmd.exec && func_reg == FUNC_STORE && !skip)
            mem_we = 1'b1;
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result.hit       <= 1'b0;
            result.hit_move  <= '0;
            result.hit_score <= '0;
            result.hit_eval  <= '0;
            result.hit_depth <= '0;
            result.hit_bound <= '0;
            result.written   <= 1'b0;
            case (func_reg)
                FUNC_PROBE:
                begin
                    if (probe_hit)
                    begin
                        result.hit       <= 1'b1;
                        result.hit_move  <= probe_entry.move;
                        result.hit_score <= probe_entry.score;
                        result.hit_eval  <= probe_entry.eval;
                        result.hit_depth <= probe_entry.depth;
                        result.hit_bound <= probe_entry.bound;
                    end
                end
                FUNC_STORE: result.written <= !skip;
                default: ;
            endcase
        end
    end

    assign result.valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/bucketed_hash_table_depth_age_replace.sv @@
// Bucketed hash table with depth/age replacement.
// Probe and store run as an accept (bucket row read) and then an execute (write back on a store).
// No new item is taken until the last one executes: the bucket row is read, modified and written back.
// Clear runs a zeroing pass over every bucket row, then executes.
// After reset the same pass runs before any item is taken.
// Depends on bht_pkg, bht_if, bht_ctrl, bht_datapath and the macros header.
`default_nettype none

`include "bucketed_hash_table_depth_age_replace_macros.svh"

module bucketed_hash_table_depth_age_replace #(
    parameter int BUCKET_BITS = 14,
    parameter int WAYS        = 4
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_we,
    input  wire [5:0]  cfg_wdata,
    bht_in_if.sink     query,
    bht_out_if.source  result
);
    import bht_pkg::*;

    // Command and status between the controller and the datapath.
    cmd_t    cmd;
    status_t status;

    // Sequence the reset sweep, accept, execute and clear sweep.
    bht_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Hold the bucket memory, the generation register and the result register.
    bht_datapath #(
        .BUCKET_BITS (BUCKET_BITS),
        .WAYS        (WAYS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .query     (query),
        .result    (result),
        .cmd       (cmd),
        .status    (status)
    );

    // Drop ready for the cycle after an accepted item: the row is in flight.
    `BHT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, query.valid && query.ready,
        !query.ready, "query ready high right after an accepted item")
    // Execute only loads the result register when it is free.
    `BHT_ASSERT_NOW(a_exec_out_free, clk, rst_n, cmd.exec,
        !result.valid || result.ready, "execute overwrote a pending result")
    // Never accept an item while a zeroing pass runs.
    `BHT_ASSERT_NOW(a_no_accept_sweep, clk, rst_n, cmd.sweep,
        !query.ready, "item accepted during a zeroing pass")

endmodule

`default_nettype wire
